// ----- rtl/homeostatic_spiking_neuron_top_macros.svh -----
// Assertion macros shared by the checker of the homeostatic spiking neuron.
`ifndef HOMEOSTATIC_SPIKING_NEURON_TOP_MACROS_SVH
`define HOMEOSTATIC_SPIKING_NEURON_TOP_MACROS_SVH

// An invariant that holds at every clock edge outside reset.
`define HSN_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define HSN_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that holds in the cycle after its cause.
`define HSN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hsn_pkg.sv -----
// Types and constants of the homeostatic spiking neuron.
package hsn_pkg;

	localparam int SYNAPSES      = 8;
	localparam int WEIGHT_MAX    = 15;
	localparam int THRESHOLD_MAX = 128;

	localparam int PULSE_W   = 8;
	localparam int FEED_W    = 16;
	localparam int CODE_W    = 2;
	localparam int CODES     = FEED_W / CODE_W;
	localparam int THR_W     = 8;
	localparam int VOLT_W    = 11;
	localparam int VOTE_W    = 8;
	localparam int WEIGHT_W  = $clog2(WEIGHT_MAX + 1);
	localparam int PROD_W    = 2 * WEIGHT_W;
	localparam int SUM_W     = PROD_W + $clog2(SYNAPSES) + 1;
	localparam int POP_W     = $clog2(SYNAPSES + 1);
	localparam int NCOUNT_W  = $clog2(CODES + 1);

	localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(4);
	localparam logic [VOLT_W-1:0] VOLT_SAT        = {VOLT_W{1'b1}};
	localparam logic [VOTE_W-1:0] VOTE_SAT        = {VOTE_W{1'b1}};

	localparam logic OP_PULSE    = 1'b0;
	localparam logic OP_REGULATE = 1'b1;

	localparam logic [CODE_W-1:0] FB_INHIBIT   = 2'd2;
	localparam logic [CODE_W-1:0] FB_STIMULATE = 2'd3;

	localparam logic [1:0] REG_IDLE      = 2'd0;
	localparam logic [1:0] REG_ACTIVE    = 2'd1;
	localparam logic [1:0] REG_INHIBIT   = 2'd2;
	localparam logic [1:0] REG_STIMULATE = 2'd3;

	typedef struct packed {
		logic              op;
		logic [PULSE_W-1:0] pulses;
		logic [FEED_W-1:0]  feedback;
	} item_t;

	typedef struct packed {
		logic              fired;
		logic [1:0]        regulation_code;
		logic [THR_W-1:0]  threshold_now;
		logic [VOLT_W-1:0] voltage_now;
	} result_t;

endpackage

// ----- rtl/homeostatic_spiking_neuron_top.sv -----
// Top level of the homeostatic spiking neuron with its input and result registers.
// The neuron takes one beat per clock cycle while the output side keeps up, and gives
// one result beat per input beat. A beat is held in the input register, its whole
// state update is computed combinationally, and the result is registered, so a result
// beat is presented from the result register after its input beat has left the input
// register, and can be taken at a clock edge when the output side is ready. The rate
// is set by the update of the neuron state, which each beat reads and writes.
// While a result waits at the output, one more input beat can still be taken.
module homeostatic_spiking_neuron_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [hsn_pkg::PULSE_W-1:0]  pulses,
	input  logic [hsn_pkg::FEED_W-1:0]   feedback,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         fired,
	output logic [1:0]                   regulation_code,
	output logic [hsn_pkg::THR_W-1:0]    threshold_now,
	output logic [hsn_pkg::VOLT_W-1:0]   voltage_now
);
	import hsn_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    take;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= '{op: op, pulses: pulses, feedback: feedback};
		if (advance)
			res_q <= res_c;
	end

	hsn_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res_c)
	);

	assign out_valid       = out_valid_q;
	assign fired           = res_q.fired;
	assign regulation_code = res_q.regulation_code;
	assign threshold_now   = res_q.threshold_now;
	assign voltage_now     = res_q.voltage_now;

endmodule

// ----- rtl/hsn_votes.sv -----
// Saturating inhibit and stimulate vote counting over the feedback codes.
module hsn_votes (
	input  logic [hsn_pkg::FEED_W-1:0] feedback,
	input  logic [hsn_pkg::VOTE_W-1:0] inhibit_votes,
	input  logic [hsn_pkg::VOTE_W-1:0] stimulate_votes,
	output logic [hsn_pkg::VOTE_W-1:0] inhibit_next,
	output logic [hsn_pkg::VOTE_W-1:0] stimulate_next
);
	import hsn_pkg::*;

	logic [NCOUNT_W-1:0] n_inh;
	logic [NCOUNT_W-1:0] n_stim;
	logic [VOTE_W:0]     sum_inh;
	logic [VOTE_W:0]     sum_stim;

	always_comb begin
		n_inh  = '0;
		n_stim = '0;
		for (int i = 0; i < CODES; i++) begin
			if (feedback[CODE_W*i +: CODE_W] == FB_INHIBIT)
				n_inh = n_inh + NCOUNT_W'(1);
			else if (feedback[CODE_W*i +: CODE_W] == FB_STIMULATE)
				n_stim = n_stim + NCOUNT_W'(1);
		end
		sum_inh  = {1'b0, inhibit_votes} + (VOTE_W+1)'(n_inh);
		sum_stim = {1'b0, stimulate_votes} + (VOTE_W+1)'(n_stim);
		inhibit_next   = sum_inh[VOTE_W] ? VOTE_SAT : sum_inh[VOTE_W-1:0];
		stimulate_next = sum_stim[VOTE_W] ? VOTE_SAT : sum_stim[VOTE_W-1:0];
	end

endmodule

// ----- rtl/hsn_core.sv -----
// Neuron state registers and the combinational next-state update for one item.
module hsn_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  hsn_pkg::item_t   item,
	output hsn_pkg::result_t result
);
	import hsn_pkg::*;

	logic [THR_W-1:0]    thr_q, thr_n, thr_up, thr_dn;
	logic [WEIGHT_W-1:0] w_q [SYNAPSES];
	logic [WEIGHT_W-1:0] w_n [SYNAPSES];
	logic [WEIGHT_W-1:0] w_up [SYNAPSES];
	logic [WEIGHT_W-1:0] w_dn [SYNAPSES];
	logic [WEIGHT_W-1:0] w_cons [SYNAPSES];
	logic [WEIGHT_W-1:0] st_q [SYNAPSES];
	logic [WEIGHT_W-1:0] st_n [SYNAPSES];
	logic [VOLT_W-1:0]   volt_q, volt_n, volt_up, volt_dn;
	logic                fire_q, fire_n;
	logic [1:0]          reg_q, reg_n, reg_keep;
	logic [VOTE_W-1:0]   inh_q, inh_n, inh_v;
	logic [VOTE_W-1:0]   stim_q, stim_n, stim_v;
	logic [SUM_W-1:0]    sum_up, sum_dn;
	logic [POP_W-1:0]    pop;
	logic                pbit;

	hsn_votes u_votes (
		.feedback        (item.feedback),
		.inhibit_votes   (inh_q),
		.stimulate_votes (stim_q),
		.inhibit_next    (inh_v),
		.stimulate_next  (stim_v)
	);

	always_comb begin
		thr_up   = (thr_q < THR_W'(THRESHOLD_MAX)) ? thr_q + THR_W'(1) : thr_q;
		thr_dn   = (thr_q != '0) ? thr_q - THR_W'(1) : thr_q;
		reg_keep = fire_q ? REG_ACTIVE : REG_IDLE;
		sum_up   = '0;
		sum_dn   = '0;
		pop      = '0;
		for (int i = 0; i < SYNAPSES; i++) begin
			w_up[i] = (w_q[i] < WEIGHT_W'(WEIGHT_MAX)) ? w_q[i] + WEIGHT_W'(1) : w_q[i];
			w_dn[i] = (w_q[i] != '0) ? w_q[i] - WEIGHT_W'(1) : w_q[i];
			w_cons[i] = (fire_q && st_q[i] != '0) ? w_up[i] : w_dn[i];
			if (w_q[i] < WEIGHT_W'(WEIGHT_MAX))
				sum_up = sum_up + SUM_W'(PROD_W'(w_up[i]) * PROD_W'(st_q[i]));
			if (w_q[i] != '0)
				sum_dn = sum_dn + SUM_W'(PROD_W'(w_dn[i]) * PROD_W'(st_q[i]));
			pbit    = (i < PULSE_W) && item.pulses[i % PULSE_W];
			st_n[i] = pbit ? w_q[i] : '0;
			pop     = pop + POP_W'(pbit);
		end
		volt_up = (sum_up > SUM_W'(VOLT_SAT)) ? VOLT_SAT : sum_up[VOLT_W-1:0];
		volt_dn = (sum_dn > SUM_W'(VOLT_SAT)) ? VOLT_SAT : sum_dn[VOLT_W-1:0];
	end

	always_comb begin
		thr_n  = thr_q;
		w_n    = w_q;
		volt_n = volt_q;
		fire_n = fire_q;
		reg_n  = reg_q;
		inh_n  = inh_q;
		stim_n = stim_q;
		if (item.op == OP_PULSE) begin
			volt_n = VOLT_W'(pop);
			fire_n = VOLT_W'(pop) > VOLT_W'(thr_q);
		end else if (inh_v > stim_v && fire_q) begin
			inh_n  = inh_v;
			stim_n = stim_v;
			thr_n  = thr_up;
			reg_n  = reg_keep;
			if (volt_q >= VOLT_W'(thr_up)) begin
				w_n    = w_dn;
				volt_n = volt_dn;
				if (volt_dn >= VOLT_W'(thr_up))
					reg_n = REG_INHIBIT;
			end
		end else if (inh_v < stim_v && !fire_q) begin
			inh_n  = inh_v;
			stim_n = stim_v;
			thr_n  = thr_dn;
			reg_n  = reg_keep;
			if (volt_q <= VOLT_W'(thr_dn)) begin
				w_n    = w_up;
				volt_n = volt_up;
				if (volt_up <= VOLT_W'(thr_dn))
					reg_n = REG_STIMULATE;
			end
		end else begin
			inh_n  = '0;
			stim_n = '0;
			w_n    = w_cons;
			reg_n  = reg_keep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RESET;
			volt_q <= '0;
			fire_q <= 1'b0;
			reg_q  <= REG_IDLE;
			inh_q  <= '0;
			stim_q <= '0;
			for (int i = 0; i < SYNAPSES; i++) begin
				w_q[i]  <= '0;
				st_q[i] <= '0;
			end
		end else if (step) begin
			thr_q  <= thr_n;
			volt_q <= volt_n;
			fire_q <= fire_n;
			reg_q  <= reg_n;
			inh_q  <= inh_n;
			stim_q <= stim_n;
			w_q    <= w_n;
			if (item.op == OP_PULSE)
				st_q <= st_n;
		end
	end

	assign result.fired           = fire_n;
	assign result.regulation_code = reg_n;
	assign result.threshold_now   = thr_n;
	assign result.voltage_now     = volt_n;

endmodule

// ----- rtl/hsn_checker.sv -----
// Port-level checker of the homeostatic spiking neuron and its binding.
`include "homeostatic_spiking_neuron_top_macros.svh"

module hsn_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         fired,
	input logic [1:0]                   regulation_code,
	input logic [hsn_pkg::THR_W-1:0]    threshold_now,
	input logic [hsn_pkg::VOLT_W-1:0]   voltage_now
);
	import hsn_pkg::*;

	`HSN_ASSERT_IMPLY(a_thr_bound, out_valid, threshold_now <= THR_W'(THRESHOLD_MAX), "threshold above its limit")
	`HSN_ASSERT_IMPLY(a_volt_bound, out_valid, voltage_now <= VOLT_W'(SYNAPSES * WEIGHT_MAX * WEIGHT_MAX), "voltage above its limit")
	`HSN_ASSERT_NEXT(a_code_hold, out_valid && !out_ready, $stable(fired) && $stable(regulation_code), "stalled spike or code changed")
	`HSN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(voltage_now) && $stable(threshold_now), "stalled result changed")

endmodule

bind homeostatic_spiking_neuron_top hsn_checker u_hsn_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.fired           (fired),
	.regulation_code (regulation_code),
	.threshold_now   (threshold_now),
	.voltage_now     (voltage_now)
);
